// File: hw/rtl/mos_pkg.sv
// Shared types and constants for the median-of-set block.
// Used by mos_cell and median_of_set_core; depends on nothing else.
package mos_pkg;

  // Width of one stored sample, signed Q8.8.
  localparam int SAMPLE_W = 16;
  // Width of the doubled median result.
  localparam int MEDIAN_W = 17;
  // Width of the status and set size fields.
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Control broadcast to every cell of the sorting chain.
  typedef struct packed {
    logic ins;   // insert the broadcast sample in order
    logic shl;   // shift every cell one place toward cell 0
    logic clr;   // empty the whole chain
  } cell_ctrl_t;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// File: hw/rtl/median_of_set_core.sv
// Median of a set of Q8.8 samples, kept sorted in a chain of cells.
// Samples that do not close the set are taken one per cycle. A closing
// transaction drains the chain by (n-1)/2 shifts toward cell 0, n being the
// stored count, and then registers its result once the output is free; input
// stalls meanwhile. Synchronous active-low reset empties the chain and the count.
// Depends on mos_pkg and mos_cell.
module median_of_set_core #(
  parameter int MAX_VALUES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_carries_value,
  input  logic signed [mos_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mos_pkg::MEDIAN_W-1:0]  out_median_doubled,
  output logic        [mos_pkg::STATUS_W-1:0]  out_status,
  output logic        [mos_pkg::SIZE_W-1:0]    out_set_size
);

  localparam int CW = $clog2(MAX_VALUES + 1);

  mos_pkg::state_t     state_r;
  mos_pkg::state_t     state_nxt;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [CW-1:0]       drain_cnt_r;
  logic [CW-1:0]       drain_cnt_nxt;
  logic                ovf_r;
  logic                ovf_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic signed [mos_pkg::MEDIAN_W-1:0] med_r;
  logic signed [mos_pkg::MEDIAN_W-1:0] med_nxt;
  logic [mos_pkg::STATUS_W-1:0]        status_r;
  logic [mos_pkg::STATUS_W-1:0]        status_nxt;
  logic [mos_pkg::SIZE_W-1:0]          size_r;
  logic [mos_pkg::SIZE_W-1:0]          size_nxt;

  logic                in_acc;
  logic                full;
  logic                out_free;
  logic [CW-1:0]       drain_target;
  logic                drain_done;
  logic                emit;
  mos_pkg::cell_ctrl_t ctrl;

  // Chain wiring; index MAX_VALUES is an empty slot past the last cell.
  logic signed [mos_pkg::SAMPLE_W-1:0] cell_val   [0:MAX_VALUES];
  logic                                cell_valid [0:MAX_VALUES];
  logic                                cell_gt    [0:MAX_VALUES-1];
  logic [MAX_VALUES-1:0]               valid_vec;

  // Input is taken only while idle; closing moves to the drain.
  assign in_stall = (state_r != mos_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CW'(MAX_VALUES));
  assign out_free = !out_valid_r || !out_stall;

  // After (n-1)/2 shifts cell 0 holds the lower middle element.
  assign drain_target = (count_r - CW'(1)) >> 1;
  assign drain_done   = (count_r == '0) || (drain_cnt_r == drain_target);
  assign emit         = (state_r == mos_pkg::ST_DRAIN) && drain_done && out_free;

  // Chain control.
  always_comb begin
    ctrl.ins = in_acc && in_carries_value && !full;
    ctrl.shl = (state_r == mos_pkg::ST_DRAIN) && !drain_done;
    ctrl.clr = emit;
  end

  // Row of cells.
  assign cell_val[MAX_VALUES]   = '0;
  assign cell_valid[MAX_VALUES] = 1'b0;

  for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
    logic signed [mos_pkg::SAMPLE_W-1:0] lval;
    logic                                lvalid;
    logic                                lgt;
    if (i == 0) begin : g_head
      assign lval   = '0;
      assign lvalid = 1'b1;
      assign lgt    = 1'b0;
    end else begin : g_body
      assign lval   = cell_val[i-1];
      assign lvalid = cell_valid[i-1];
      assign lgt    = cell_gt[i-1];
    end
    mos_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample      (in_sample),
      .left_val    (lval),
      .left_valid  (lvalid),
      .left_gt     (lgt),
      .right_val   (cell_val[i+1]),
      .right_valid (cell_valid[i+1]),
      .val         (cell_val[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
    assign valid_vec[i] = cell_valid[i];
  end

  // Sequencer, count and overflow flag.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    drain_cnt_nxt = drain_cnt_r;
    unique case (state_r)
      mos_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_carries_value) begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              count_nxt = count_r + CW'(1);
            end
          end
          if (in_last) begin
            state_nxt     = mos_pkg::ST_DRAIN;
            drain_cnt_nxt = '0;
          end
        end
      end
      mos_pkg::ST_DRAIN: begin
        if (!drain_done) begin
          drain_cnt_nxt = drain_cnt_r + CW'(1);
        end else if (out_free) begin
          state_nxt = mos_pkg::ST_IDLE;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = mos_pkg::ST_IDLE;
      end
    endcase
  end

  // Result formation from the two cells nearest cell 0.
  always_comb begin
    med_nxt    = med_r;
    status_nxt = status_r;
    size_nxt   = size_r;
    if (emit) begin
      size_nxt = mos_pkg::SIZE_W'(count_r);
      if (count_r == '0) begin
        med_nxt    = '0;
        status_nxt = mos_pkg::STATUS_EMPTY;
      end else begin
        if (count_r[0]) begin
          med_nxt = {cell_val[0], 1'b0};
        end else begin
          med_nxt = mos_pkg::MEDIAN_W'(cell_val[0]) + mos_pkg::MEDIAN_W'(cell_val[1]);
        end
        status_nxt = ovf_r ? mos_pkg::STATUS_OVERFLOW : mos_pkg::STATUS_OK;
      end
    end
  end

  // Output register holds a result until the downstream side takes it.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mos_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    med_r    <= med_nxt;
    status_r <= status_nxt;
    size_r   <= size_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = med_r;
  assign out_status         = status_r;
  assign out_set_size       = size_r;

  // The count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VALUES))
    else $error("stored count exceeds chain length");

  // Occupied cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + MAX_VALUES'(1)) & valid_vec) == '0)
    else $error("chain has a gap between occupied cells");

  // While idle, the occupied cells match the count.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mos_pkg::ST_IDLE |-> $countones(valid_vec) == int'(count_r))
    else $error("occupied cells differ from count");

  // A result empties the chain and the count.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (count_r == '0) && (valid_vec == '0) && !ovf_r)
    else $error("set not emptied after result");

endmodule

// File: hw/rtl/mos_cell.sv
// One cell of the sorted insertion chain: holds one sample and a valid bit.
// Depends on mos_pkg for the control struct and sample width.
module mos_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mos_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [mos_pkg::SAMPLE_W-1:0] sample,
  // Neighbor toward cell 0.
  input  logic signed [mos_pkg::SAMPLE_W-1:0] left_val,
  input  logic                                left_valid,
  input  logic                                left_gt,
  // Neighbor away from cell 0.
  input  logic signed [mos_pkg::SAMPLE_W-1:0] right_val,
  input  logic                                right_valid,
  output logic signed [mos_pkg::SAMPLE_W-1:0] val,
  output logic                                valid,
  output logic                                gt
);

  logic signed [mos_pkg::SAMPLE_W-1:0] val_r;
  logic signed [mos_pkg::SAMPLE_W-1:0] val_nxt;
  logic                                valid_r;
  logic                                valid_nxt;

  // This cell holds a value larger than the sample, so it must move right.
  assign gt = valid_r && (val_r > sample);

  // Insertion: take the left value when it moves right, or take the sample
  // when this is the slot where it belongs. Shift and clear for draining.
  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.shl) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt   = left_val;
        valid_nxt = 1'b1;
      end else if (left_valid && (gt || !valid_r)) begin
        val_nxt   = sample;
        valid_nxt = 1'b1;
      end
    end
  end

  // Sample storage needs no reset.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule

// File: dv/median_of_set_checker.sv
// Checker for median_of_set_core: keeps its own sorted copy of each set and
// compares every result transaction with the predicted median, field by field.
// Depends on mos_pkg for the field widths and status codes.
module median_of_set_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 in_carries_value,
  input  logic signed [mos_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_last,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [mos_pkg::MEDIAN_W-1:0]  out_median_doubled,
  input  logic        [mos_pkg::STATUS_W-1:0]  out_status,
  input  logic        [mos_pkg::SIZE_W-1:0]    out_set_size,
  output int unsigned                          fail_count,
  output int unsigned                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mos_pkg::*;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic        [STATUS_W-1:0] status;
    logic        [SIZE_W-1:0]   set_size;
  } median_result_t;

  // Predicted contents of the sorting chain, ascending.
  logic signed [SAMPLE_W-1:0] sorted_samples [CAPACITY];
  int unsigned                sample_count;
  logic                       dropped_any;
  median_result_t             expected_medians [$];

  // Predict on each accepted input transaction, then check each accepted result.
  always @(posedge clk) begin
    int unsigned                pos;
    int unsigned                mid;
    logic signed [MEDIAN_W-1:0] lower;
    logic signed [MEDIAN_W-1:0] upper;
    median_result_t             want;
    median_result_t             got;
    if (!rst_n) begin
      sample_count = 0;
      dropped_any  = 1'b0;
      fail_count   = 0;
      expected_medians.delete();
    end else begin
      if (in_valid && !in_stall) begin
        // Insertion sort; once the chain is full, further samples are dropped.
        if (in_carries_value) begin
          if (sample_count >= CAPACITY) begin
            dropped_any = 1'b1;
          end else begin
            pos = sample_count;
            while (pos > 0 && sorted_samples[pos-1] > in_sample) begin
              sorted_samples[pos] = sorted_samples[pos-1];
              pos--;
            end
            sorted_samples[pos] = in_sample;
            sample_count++;
          end
        end
        // A closing transaction yields the doubled median and empties the set.
        if (in_last) begin
          want = '0;
          if (sample_count == 0) begin
            want.status = STATUS_EMPTY;
          end else begin
            mid   = sample_count / 2;
            upper = sorted_samples[mid];
            if (sample_count % 2 == 0) begin
              lower = sorted_samples[mid-1];
            end else begin
              lower = upper;
            end
            want.median_doubled = upper + lower;
            want.status         = dropped_any ? STATUS_OVERFLOW : STATUS_OK;
          end
          want.set_size = SIZE_W'(sample_count);
          expected_medians.push_back(want);
          sample_count = 0;
          dropped_any  = 1'b0;
        end
      end

      if (out_valid && !out_stall) begin
        got = '{out_median_doubled, out_status, out_set_size};
        if (expected_medians.size() == 0) begin
          if (fail_count < 10) begin
            $display("ERROR %0t: unexpected result median_doubled=%0d status=%0d size=%0d",
                     $realtime, got.median_doubled, got.status, got.set_size);
          end
          fail_count++;
        end else begin
          want = expected_medians.pop_front();
          if (got.median_doubled !== want.median_doubled || got.status !== want.status ||
              got.set_size !== want.set_size) begin
            if (fail_count < 10) begin
              $display({"ERROR %0t: median_doubled exp %0d got %0d, ",
                        "status exp %0d got %0d, size exp %0d got %0d"},
                       $realtime, want.median_doubled, got.median_doubled, want.status,
                       got.status, want.set_size, got.set_size);
            end
            fail_count++;
          end
        end
      end
    end
    pending = expected_medians.size();
  end

endmodule

// File: dv/tb_median_of_set_core.sv
// Testbench top for median_of_set_core: drives directed and random sets of
// Q8.8 samples with random idling on both sides and gives the verdict.
// Depends on mos_pkg, median_of_set_core and median_of_set_checker.
module tb_median_of_set_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mos_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = CAPACITY + 16;
  localparam int CYCLE_LIMIT  = 300000;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_carries_value = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample        = '0;
  logic                       in_last          = 1'b0;
  logic                       out_stall        = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic signed [MEDIAN_W-1:0] out_median_doubled;
  logic        [STATUS_W-1:0] out_status;
  logic        [SIZE_W-1:0]   out_set_size;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 65;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;

  median_of_set_core #(.MAX_VALUES(CAPACITY)) dut (.*);

  median_of_set_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

  always #10 clk = ~clk;

  // Receiver back-pressure and the run timeout.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one transaction, with a random gap first, and wait until accepted.
  task automatic send_item(input logic carries, input logic signed [SAMPLE_W-1:0] value,
                           input logic closes);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_carries_value <= carries;
    in_sample        <= value;
    in_last          <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (carries || closes) items_sent++;
  endtask

  // Mostly full-range values, with extremes and a narrow band for duplicates.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3, 4: return SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // One set of the given length, with stray no-op transactions mixed in.
  task automatic send_set(input int unsigned length);
    for (int unsigned i = 0; i < length; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(1'b0, random_sample(), 1'b0);
      if (i == length - 1 && $urandom_range(0, 1) == 1) begin
        send_item(1'b1, random_sample(), 1'b1);
        return;
      end
      send_item(1'b1, random_sample(), 1'b0);
    end
    send_item(1'b0, random_sample(), 1'b1);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty sets, a stray no-op, extremes, odd and even counts.
    send_item(1'b0, 16'sh0000, 1'b1);
    send_item(1'b0, 16'sh5A5A, 1'b0);
    send_item(1'b0, 16'shFFFF, 1'b1);
    send_item(1'b1, 16'sh7FFF, 1'b1);
    send_item(1'b1, 16'sh8000, 1'b1);
    send_item(1'b1, 16'sh7FFF, 1'b0);
    send_item(1'b1, 16'sh7FFF, 1'b1);
    send_item(1'b1, 16'sh8000, 1'b0);
    send_item(1'b1, 16'sh8000, 1'b0);
    send_item(1'b0, 16'sh1234, 1'b1);
    send_item(1'b1, 16'sh012C, 1'b0);
    send_item(1'b1, -16'sd5,    1'b0);
    send_item(1'b1, 16'sh0064, 1'b0);
    send_item(1'b1, -16'sd5,    1'b0);
    send_item(1'b1, 16'sh0007, 1'b1);
    send_item(1'b1, 16'sh7FFF, 1'b0);
    send_item(1'b1, 16'sh8000, 1'b1);
    send_item(1'b1, 16'sh0004, 1'b0);
    send_item(1'b0, 16'sh0000, 1'b0);
    send_item(1'b1, 16'sh0008, 1'b1);

    // Random sets: mostly short, some medium, a few around and past capacity.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent - random_start >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent - random_start >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 13;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_set(0);
      end else if (pick < 75) begin
        send_set($urandom_range(1, 8));
      end else if (pick < 91) begin
        send_set($urandom_range(9, 30));
      end else begin
        send_set($urandom_range(CAPACITY - 4, CAPACITY + 8));
      end
    end
    in_valid <= 1'b0;

    // Let every expected result arrive, then allow the block to settle.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
